// ===== rtl/ffa_pkg.sv =====
`default_nettype none

package ffa_pkg;

    // Fixed widths of the item fields.
    localparam int REQ_W   = 15;
    localparam int FADDR_W = 14;
    localparam int ADDR_W  = 14;
    localparam int STAT_W  = 2;
    localparam int LIMIT_W = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd4;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FAULT = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] status;
    } ffa_result_t;

endpackage

`default_nettype wire

// ===== rtl/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator with in-band chunk headers.
// Input channel (in_valid / in_stall): kind selects allocate or free; req_size is
// the byte count of an allocate item, free_addr the data offset of a free item.
// Output channel (out_valid / out_stall): one result per item, block_addr and status.
// cfg_we / cfg_wdata write heap_limit_pages; write it only while the block is idle.
// Items are taken one at a time. An allocate item reads one chunk header after another
// along the walk, grows the heap by whole pages at the top when the walk reaches it,
// and writes the chosen chunk's header, plus a remainder header when it is split. A free
// item reads its header, then each following free header while merging; an ignored free
// address, or any item after a fault, goes straight to its result. The result shows on
// out_valid in the same cycle in which the block can take the next item. Every header
// access is a read or a write of the single header memory, so the length of the chunk
// walk sets the rate.
// After reset a clearing pass writes all HEAP_PAGES * PAGE_BYTES header entries, one
// per cycle; in_stall stays high during it.
// A finished result sits in an output register; the next item is accepted while it
// waits, but the following result is held until out_stall drops.
// A heap fault is sticky until reset: every later item answers with the fault status.
`default_nettype none

module first_fit_heap_allocator_core
    import ffa_pkg::*;
#(
    parameter int HEAP_PAGES   = 4,
    parameter int PAGE_BYTES   = 4096,
    parameter int MIN_CHUNK    = 16,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic [REQ_W-1:0]   req_size,
    input  wire logic [FADDR_W-1:0] free_addr,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [ADDR_W-1:0]  block_addr,
    output logic      [STAT_W-1:0]  status,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata
);

    localparam int HEAP_BYTES = HEAP_PAGES * PAGE_BYTES;
    localparam int AW = $clog2(HEAP_BYTES);
    localparam int DW = AW + 2;

    logic [LIMIT_W-1:0] limit_reg;
    logic               out_valid_reg;
    ffa_result_t        out_res_reg;
    logic               walker_ready;
    logic               slot_free;
    logic               res_valid;
    ffa_result_t        res;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [DW-1:0]      rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DW-1:0]      wr_data;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = !walker_ready;

    ffa_hdr_ram #(
        .DEPTH (HEAP_BYTES),
        .AW    (AW),
        .DW    (DW)
    ) u_hdr_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ffa_walker #(
        .HEAP_PAGES   (HEAP_PAGES),
        .PAGE_BYTES   (PAGE_BYTES),
        .MIN_CHUNK    (MIN_CHUNK),
        .HEADER_BYTES (HEADER_BYTES),
        .AW           (AW),
        .DW           (DW)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .kind        (kind),
        .req_size    (req_size),
        .free_addr   (free_addr),
        .ready       (walker_ready),
        .limit_pages (limit_reg),
        .slot_free   (slot_free),
        .res_valid   (res_valid),
        .res         (res),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (res_valid && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && slot_free)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign block_addr = out_res_reg.addr;
    assign status     = out_res_reg.status;

endmodule

`default_nettype wire

// ===== rtl/ffa_hdr_ram.sv =====
`default_nettype none

module ffa_hdr_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 16
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] hdr_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= hdr_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/ffa_walker.sv =====
`default_nettype none

module ffa_walker
    import ffa_pkg::*;
#(
    parameter int HEAP_PAGES   = 4,
    parameter int PAGE_BYTES   = 4096,
    parameter int MIN_CHUNK    = 16,
    parameter int HEADER_BYTES = 8,
    parameter int AW           = 14,
    parameter int DW           = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               kind,
    input  wire logic [REQ_W-1:0]   req_size,
    input  wire logic [FADDR_W-1:0] free_addr,
    output logic                    ready,
    input  wire logic [LIMIT_W-1:0] limit_pages,
    input  wire logic               slot_free,
    output logic                    res_valid,
    output ffa_result_t             res,
    output logic                    rd_en,
    output logic      [AW-1:0]      rd_addr,
    input  wire logic [DW-1:0]      rd_data,
    output logic                    wr_en,
    output logic      [AW-1:0]      wr_addr,
    output logic      [DW-1:0]      wr_data
);

    localparam int HEAP_BYTES = HEAP_PAGES * PAGE_BYTES;
    localparam int SW = DW - 1;
    localparam int CW = (SW + 1 > REQ_W + 1) ? SW + 1 : REQ_W + 1;
    localparam int PW = $clog2(HEAP_PAGES + 1);
    localparam int NW = (PW + 1 > LIMIT_W + 1) ? PW + 1 : LIMIT_W + 1;

    localparam logic [CW-1:0] SIZE_MAX  = CW'((2 ** SW) - 1);
    localparam logic [CW-1:0] HDR_C     = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] MIN_C     = CW'(MIN_CHUNK);
    localparam logic [CW-1:0] PAGE_C    = CW'(PAGE_BYTES);
    localparam logic [SW-1:0] PAGE_S    = SW'(PAGE_BYTES);
    localparam logic [NW-1:0] PAGES_C   = NW'(HEAP_PAGES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HEAP_BYTES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACHK,
        S_GROW,
        S_ARD,
        S_SPLIT,
        S_FHDR,
        S_FMRG,
        S_RESP
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [SW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   acc_reg, acc_next;
    logic [CW-1:0]   rs_reg, rs_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [NW-1:0]   top_pages_reg, top_pages_next;
    logic [SW-1:0]   top_bytes_reg, top_bytes_next;
    logic            faulted_reg, faulted_next;
    ffa_result_t     res_reg, res_next;

    logic [CW-1:0]   rd_size;
    logic            rd_used;
    logic [CW-1:0]   pos_c;
    logic [CW-1:0]   top_c;
    logic [CW-1:0]   walk_sum;
    logic [CW-1:0]   merge_sum;
    logic [CW-1:0]   merge_acc;
    logic [CW-1:0]   merge_next;
    logic [CW-1:0]   req_pad;
    logic [CW-1:0]   real_size;
    logic [CW-1:0]   free_pos;
    logic [CW-1:0]   split_rest;
    logic [CW-1:0]   split_addr;
    logic [CW-1:0]   data_addr;
    logic [NW-1:0]   lim;
    logic [NW-1:0]   pages_sum;

    assign rd_size    = CW'(rd_data[SW-1:0]);
    assign rd_used    = rd_data[SW];
    assign pos_c      = CW'(pos_reg);
    assign top_c      = CW'(top_bytes_reg);
    assign walk_sum   = pos_c + rd_size;
    assign merge_sum  = acc_reg + rd_size;
    // Merged sizes saturate; any saturated size already lies beyond the top.
    assign merge_acc  = (merge_sum > SIZE_MAX) ? SIZE_MAX : merge_sum;
    assign merge_next = pos_c + merge_acc;
    assign req_pad    = CW'(req_size) + HDR_C;
    assign real_size  = (req_pad < MIN_C) ? MIN_C : req_pad;
    assign free_pos   = CW'(free_addr) - HDR_C;
    assign split_rest = rd_size - rs_reg;
    assign split_addr = pos_c + rs_reg;
    assign data_addr  = pos_c + HDR_C;
    assign lim        = (NW'(limit_pages) > PAGES_C) ? PAGES_C : NW'(limit_pages);
    assign pages_sum  = top_pages_reg + n_reg;

    assign ready     = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        rs_next        = rs_reg;
        n_next         = n_reg;
        top_pages_next = top_pages_reg;
        top_bytes_next = top_bytes_reg;
        faulted_next   = faulted_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Clearing pass: offset 0 receives the first page as one free chunk.
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = (clr_addr_reg == '0) ? {1'b0, PAGE_S} : '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '{addr: '0, status: STAT_OK};
                    if (faulted_reg)
                    begin
                        res_next.status = STAT_FAULT;
                        state_next      = S_RESP;
                    end
                    else if (kind == KIND_ALLOC)
                    begin
                        rs_next    = real_size;
                        pos_next   = '0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_ACHK;
                    end
                    else if ((CW'(free_addr) < HDR_C) || (free_pos >= top_c))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        pos_next   = free_pos[SW-1:0];
                        rd_en      = 1'b1;
                        rd_addr    = free_pos[AW-1:0];
                        state_next = S_FHDR;
                    end
                end
            end

            S_ACHK:
            begin
                if (rd_used || (rd_size < rs_reg))
                begin
                    if (rd_size == '0)
                    begin
                        faulted_next    = 1'b1;
                        res_next.status = STAT_FAULT;
                        state_next      = S_RESP;
                    end
                    else if (walk_sum == top_c)
                    begin
                        pos_next   = walk_sum[SW-1:0];
                        n_next     = NW'(1);
                        acc_next   = PAGE_C;
                        state_next = S_GROW;
                    end
                    else if (walk_sum > top_c)
                    begin
                        faulted_next    = 1'b1;
                        res_next.status = STAT_FAULT;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        pos_next = walk_sum[SW-1:0];
                        rd_en    = 1'b1;
                        rd_addr  = walk_sum[AW-1:0];
                    end
                end
                else if (rd_size > top_c - pos_c)
                begin
                    faulted_next    = 1'b1;
                    res_next.status = STAT_FAULT;
                    state_next      = S_RESP;
                end
                else
                begin
                    res_next.addr = data_addr[ADDR_W-1:0];
                    if (split_rest < MIN_C)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = pos_reg[AW-1:0];
                        wr_data    = {1'b1, rd_size[SW-1:0]};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        // Remainder header now, the taken chunk's header next cycle.
                        wr_en      = 1'b1;
                        wr_addr    = split_addr[AW-1:0];
                        wr_data    = {1'b0, split_rest[SW-1:0]};
                        state_next = S_SPLIT;
                    end
                end
            end

            S_GROW:
            begin
                // Counts pages one at a time until n pages exceed the padded request or the limit.
                if (pages_sum > lim)
                begin
                    res_next.status = STAT_OOM;
                    state_next      = S_RESP;
                end
                else if (acc_reg > rs_reg)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = pos_reg[AW-1:0];
                    wr_data        = {1'b0, acc_reg[SW-1:0]};
                    top_pages_next = pages_sum;
                    top_bytes_next = top_bytes_reg + acc_reg[SW-1:0];
                    state_next     = S_ARD;
                end
                else
                begin
                    n_next   = n_reg + 1'b1;
                    acc_next = acc_reg + PAGE_C;
                end
            end

            S_ARD:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg[AW-1:0];
                state_next = S_ACHK;
            end

            S_SPLIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_data    = {1'b1, rs_reg[SW-1:0]};
                state_next = S_RESP;
            end

            S_FHDR:
            begin
                // After a fault nothing is read again, so no header write is needed.
                if (rd_size == '0)
                begin
                    faulted_next    = 1'b1;
                    res_next.status = STAT_FAULT;
                    state_next      = S_RESP;
                end
                else if (walk_sum < top_c)
                begin
                    acc_next   = rd_size;
                    rd_en      = 1'b1;
                    rd_addr    = walk_sum[AW-1:0];
                    state_next = S_FMRG;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[AW-1:0];
                    wr_data    = {1'b0, rd_size[SW-1:0]};
                    state_next = S_RESP;
                end
            end

            S_FMRG:
            begin
                if (rd_used)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[AW-1:0];
                    wr_data    = {1'b0, acc_reg[SW-1:0]};
                    state_next = S_RESP;
                end
                else if (rd_size == '0)
                begin
                    faulted_next    = 1'b1;
                    res_next.status = STAT_FAULT;
                    state_next      = S_RESP;
                end
                else if (merge_next < top_c)
                begin
                    acc_next = merge_acc;
                    rd_en    = 1'b1;
                    rd_addr  = merge_next[AW-1:0];
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[AW-1:0];
                    wr_data    = {1'b0, merge_acc[SW-1:0]};
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            rs_reg        <= '0;
            n_reg         <= '0;
            top_pages_reg <= NW'(1);
            top_bytes_reg <= PAGE_S;
            faulted_reg   <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            rs_reg        <= rs_next;
            n_reg         <= n_next;
            top_pages_reg <= top_pages_next;
            top_bytes_reg <= top_bytes_next;
            faulted_reg   <= faulted_next;
            res_reg       <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ffa_checker.sv =====
`default_nettype none

module ffa_checker
    import ffa_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [ADDR_W-1:0] block_addr,
    input wire logic [STAT_W-1:0] status
);

    logic seen_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_fault_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && (status == STAT_FAULT))
        begin
            seen_fault_reg <= 1'b1;
        end
    end

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_OK || status == STAT_OOM || status == STAT_FAULT))
        else $error("result status carries an unused code");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> (block_addr == '0))
        else $error("failed item reports a nonzero address");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_fault_reg |-> (status == STAT_FAULT))
        else $error("result after a heap fault is not a fault");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(block_addr) && $stable(status))
        else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator_core ffa_checker u_ffa_checker (.*);

`default_nettype wire

// ===== bench/tb_first_fit_heap_allocator_core.sv =====
`default_nettype none

module tb_first_fit_heap_allocator_core;
    import ffa_pkg::*;

    localparam int HEAP_PAGES   = 4;
    localparam int PAGE_BYTES   = 4096;
    localparam int MIN_CHUNK    = 16;
    localparam int HEADER_BYTES = 8;
    localparam int HEAP_BYTES   = HEAP_PAGES * PAGE_BYTES;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int TAIL_CYCLES  = 64;

    typedef struct packed {
        logic               kind;
        logic [REQ_W-1:0]   req;
        logic [FADDR_W-1:0] faddr;
    } heap_cmd_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               kind      = KIND_ALLOC;
    logic [REQ_W-1:0]   req_size  = '0;
    logic [FADDR_W-1:0] free_addr = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ADDR_W-1:0]  block_addr;
    logic [STAT_W-1:0]  status;
    logic               cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;

    first_fit_heap_allocator_core #(
        .HEAP_PAGES   (HEAP_PAGES),
        .PAGE_BYTES   (PAGE_BYTES),
        .MIN_CHUNK    (MIN_CHUNK),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .req_size   (req_size),
        .free_addr  (free_addr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_addr (block_addr),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // Shadow copy of the heap: chunk headers, top of heap and fault flag.
    int unsigned       chunk_size [HEAP_BYTES];
    bit                chunk_used [HEAP_BYTES];
    int unsigned       top_pages;
    int unsigned       limit_pages;
    bit                heap_faulted;

    heap_cmd_t         pending_q [$];
    ffa_result_t       heap_expect_q [$];
    logic [ADDR_W-1:0] live_blocks [$];
    logic [ADDR_W-1:0] last_freed = '0;
    ffa_result_t       heap_want;
    heap_cmd_t         next_cmd;

    bit                in_took = 1'b0;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int                mismatches     = 0;
    int                cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic heap_reset();
        for (int i = 0; i < HEAP_BYTES; i++)
        begin
            chunk_size[i] = 0;
            chunk_used[i] = 1'b0;
        end
        chunk_size[0] = PAGE_BYTES;
        top_pages     = 1;
        limit_pages   = 32'(LIMIT_RESET);
        heap_faulted  = 1'b0;
    endtask

    function automatic ffa_result_t heap_fault();
        heap_faulted = 1'b1;
        return '{addr: '0, status: STAT_FAULT};
    endfunction

    function automatic ffa_result_t heap_alloc(input int unsigned req);
        int unsigned need;
        int unsigned pos;
        int unsigned grow;
        int unsigned top;
        int unsigned cap;
        need = HEADER_BYTES + req;
        if (need < MIN_CHUNK)
            need = MIN_CHUNK;
        cap = (limit_pages > HEAP_PAGES) ? HEAP_PAGES : limit_pages;
        pos = 0;
        while (chunk_used[pos] || chunk_size[pos] < need)
        begin
            if (chunk_size[pos] == 0)
                return heap_fault();
            pos += chunk_size[pos];
            top = top_pages * PAGE_BYTES;
            if (pos == top)
            begin
                grow = need / PAGE_BYTES + 1;
                if (top_pages + grow > cap)
                    return '{addr: '0, status: STAT_OOM};
                // The new region's header goes at the old top of the heap.
                chunk_size[pos] = grow * PAGE_BYTES;
                chunk_used[pos] = 1'b0;
                top_pages += grow;
            end
            else if (pos > top)
                return heap_fault();
        end
        top = top_pages * PAGE_BYTES;
        if (chunk_size[pos] > top - pos)
            return heap_fault();
        if (chunk_size[pos] - need >= MIN_CHUNK)
        begin
            chunk_size[pos + need] = chunk_size[pos] - need;
            chunk_used[pos + need] = 1'b0;
            chunk_size[pos]        = need;
        end
        chunk_used[pos] = 1'b1;
        return '{addr: ADDR_W'(pos + HEADER_BYTES), status: STAT_OK};
    endfunction

    function automatic ffa_result_t heap_free(input int unsigned addr);
        int unsigned pos;
        int unsigned nxt;
        int unsigned top;
        top = top_pages * PAGE_BYTES;
        if (addr < HEADER_BYTES || addr - HEADER_BYTES >= top)
            return '{addr: '0, status: STAT_OK};
        pos = addr - HEADER_BYTES;
        chunk_used[pos] = 1'b0;
        if (chunk_size[pos] == 0)
            return heap_fault();
        nxt = pos + chunk_size[pos];
        while (nxt < top && !chunk_used[nxt])
        begin
            if (chunk_size[nxt] == 0)
                return heap_fault();
            chunk_size[pos] += chunk_size[nxt];
            nxt = pos + chunk_size[pos];
        end
        return '{addr: '0, status: STAT_OK};
    endfunction

    function automatic ffa_result_t heap_predict(input heap_cmd_t cmd);
        if (heap_faulted)
            return '{addr: '0, status: STAT_FAULT};
        if (cmd.kind == KIND_ALLOC)
            return heap_alloc(32'(cmd.req));
        return heap_free(32'(cmd.faddr));
    endfunction

    // Driver: a new item is presented only when the line is empty or the last one was taken.
    always @(negedge clk)
    begin
        if (!in_valid || in_took)
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_cmd  = pending_q.pop_front();
                in_valid  <= 1'b1;
                kind      <= next_cmd.kind;
                req_size  <= next_cmd.req;
                free_addr <= next_cmd.faddr;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: predicts on every accepted item and checks every accepted result.
    always @(posedge clk)
    begin
        in_took = in_valid && !in_stall;
        if (cfg_we)
            limit_pages = 32'(cfg_wdata);
        if (in_took)
        begin
            heap_want = heap_predict('{kind: kind, req: req_size, faddr: free_addr});
            heap_expect_q.push_back(heap_want);
            if (kind == KIND_ALLOC && heap_want.status == STAT_OK)
                live_blocks.push_back(heap_want.addr);
        end
        if (out_valid && !out_stall)
        begin
            if (heap_expect_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got block_addr %0d status %0d",
                         $time, block_addr, status);
            end
            else
            begin
                heap_want = heap_expect_q.pop_front();
                if (block_addr !== heap_want.addr)
                begin
                    mismatches++;
                    $display("%0t: block_addr mismatch: expected %0d, got %0d",
                             $time, heap_want.addr, block_addr);
                end
                if (status !== heap_want.status)
                begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, heap_want.status, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("first_fit_heap_allocator_core verification failed");
            $finish;
        end
    end

    task automatic queue_cmd(input logic k, input logic [REQ_W-1:0] r,
                             input logic [FADDR_W-1:0] f);
        while (pending_q.size() >= 2)
        begin
            @(posedge clk);
            #1;
        end
        pending_q.push_back('{kind: k, req: r, faddr: f});
    endtask

    task automatic alloc_cmd(input logic [REQ_W-1:0] r);
        queue_cmd(KIND_ALLOC, r, FADDR_W'($urandom));
    endtask

    task automatic free_cmd(input logic [FADDR_W-1:0] f);
        queue_cmd(KIND_FREE, REQ_W'($urandom), f);
    endtask

    task automatic wait_heap_idle();
        while (pending_q.size() != 0 || in_valid || heap_expect_q.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] pages);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= pages;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly small requests so that chunk walks stay short; a few reach past the heap.
    function automatic logic [REQ_W-1:0] pick_req();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return REQ_W'($urandom_range(64));
        if (r < 90)
            return REQ_W'($urandom_range(1024, 65));
        if (r < 98)
            return REQ_W'($urandom_range(6000, 1025));
        return REQ_W'($urandom_range(32767, 6001));
    endfunction

    task automatic run_random(input int count);
        int          done;
        int unsigned pick;
        int unsigned idx;
        logic [ADDR_W-1:0] blk;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                free_cmd(FADDR_W'($urandom_range(HEADER_BYTES - 1)));
            else if (pick < 9 && last_freed != 0)
            begin
                free_cmd(last_freed);
                done++;
            end
            else if (live_blocks.size() != 0 && (pick < 50 || live_blocks.size() > 40))
            begin
                idx = $urandom_range(live_blocks.size() - 1);
                blk = live_blocks[idx];
                live_blocks.delete(idx);
                last_freed = blk;
                free_cmd(blk);
                done++;
            end
            else
            begin
                alloc_cmd(pick_req());
                done++;
            end
        end
    endtask

    initial
    begin
        heap_reset();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;
        // Wait out the header clearing pass.
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
            #1;
        end

        // A single page: small chunks, minimum size, out of memory.
        write_limit(3'd1);
        alloc_cmd(15'd0);
        alloc_cmd(15'd7);
        alloc_cmd(15'd8);
        alloc_cmd(15'd9);
        alloc_cmd(15'd5000);
        alloc_cmd(15'd32767);
        free_cmd(14'd0);
        free_cmd(14'd7);
        free_cmd(14'd16383);
        free_cmd(14'd24);
        free_cmd(14'd8);
        alloc_cmd(15'd3);
        wait_heap_idle();

        // Two pages: one growth step between requests that would overshoot.
        write_limit(3'd2);
        alloc_cmd(15'd5000);
        alloc_cmd(15'd4000);
        alloc_cmd(15'd3000);
        alloc_cmd(15'd16384);
        free_cmd(14'd73);
        free_cmd(14'd4104);
        alloc_cmd(15'd100);

        wait_heap_idle();
        write_limit(3'd0);
        run_random(160);

        wait_heap_idle();
        write_limit(3'd3);
        send_idle_pct = 67;
        run_random(160);

        wait_heap_idle();
        write_limit(3'd7);
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        run_random(160);

        wait_heap_idle();
        write_limit(3'd4);
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        run_random(160);

        // Freeing an offset that holds no header hits a zero-size chunk; the fault sticks.
        wait_heap_idle();
        free_cmd(14'd9);
        alloc_cmd(15'd10);
        free_cmd(14'd8);

        wait_heap_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("first_fit_heap_allocator_core verification clean");
        else
            $display("first_fit_heap_allocator_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
